>>> design/tnzm_pkg.sv
// ----------------------------------------------------------------------------
// tnzm_pkg
// Shared types and constants for the touchpad numpad zone mapper.
// ----------------------------------------------------------------------------
package tnzm_pkg;

    localparam int PosW    = 16;
    localparam int GridW   = 5;
    localparam int KeyW    = 4;
    localparam int ActW    = 3;
    localparam int KindW   = 2;
    localparam int PaddrW  = 4;
    localparam int PdataW  = 32;

    typedef logic [ActW-1:0]  action_t;
    typedef logic [KindW-1:0] kind_t;
    typedef logic [1:0]       phase_t;

    localparam action_t ACT_NONE    = 3'd0;
    localparam action_t ACT_ON      = 3'd1;
    localparam action_t ACT_OFF     = 3'd2;
    localparam action_t ACT_BRIGHT  = 3'd3;
    localparam action_t ACT_PRESS   = 3'd4;
    localparam action_t ACT_RELEASE = 3'd5;

    localparam kind_t KIND_X      = 2'd0;
    localparam kind_t KIND_Y      = 2'd1;
    localparam kind_t KIND_FINGER = 2'd2;
    localparam kind_t KIND_NOP    = 2'd3;

    localparam phase_t PH_IDLE     = 2'd0;
    localparam phase_t PH_TOUCHED  = 2'd1;
    localparam phase_t PH_CONSUMED = 2'd2;

    localparam logic [PaddrW-1:0] ADDR_X_MAX = 4'h0;
    localparam logic [PaddrW-1:0] ADDR_Y_MAX = 4'h4;
    localparam logic [PaddrW-1:0] ADDR_COLS  = 4'h8;
    localparam logic [PaddrW-1:0] ADDR_ROWS  = 4'hC;

    localparam logic [PosW-1:0]  X_MAX_RST = 16'hFFFF;
    localparam logic [PosW-1:0]  Y_MAX_RST = 16'hFFFF;
    localparam logic [GridW-1:0] COLS_RST  = 5'd5;
    localparam logic [GridW-1:0] ROWS_RST  = 5'd5;

    function automatic logic [GridW-1:0] clamp_grid(input logic [GridW-1:0] n);
        logic [GridW-1:0] r;
        if (n == '0)
            r = 5'd1;
        else if (n > 5'd16)
            r = 5'd16;
        else
            r = n;
        return r;
    endfunction

endpackage

>>> design/touchpad_numpad_zone_mapper.sv
// ----------------------------------------------------------------------------
// touchpad_numpad_zone_mapper
// Maps touchpad position and finger beats to numpad on/off, brightness,
// key press and key release actions; one result beat per input beat.
// ----------------------------------------------------------------------------
// Position beats, ignored beats and finger beats that press no key issue their
// result directly. A finger-down that presses a key runs two 6-step restoring
// divisions (column, then row) on one shared compare/subtract unit and then
// issues its result. in_stall is high while a division runs or its result
// waits to issue, or while a waiting result is stalled.
module touchpad_numpad_zone_mapper
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tnzm_pkg::PaddrW-1:0]   paddr,
    input  logic [tnzm_pkg::PdataW-1:0]   pwdata,
    output logic [tnzm_pkg::PdataW-1:0]   prdata,
    output logic                          pready,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [tnzm_pkg::KindW-1:0]    event_kind,
    input  logic [tnzm_pkg::PosW-1:0]     event_value,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [tnzm_pkg::ActW-1:0]     action,
    output logic [tnzm_pkg::KeyW-1:0]     key_row,
    output logic [tnzm_pkg::KeyW-1:0]     key_column
);
    import tnzm_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_OUT  = 2'd2;

    localparam int DvdW = 24;
    localparam int DvsW = 20;
    localparam int TrW  = 26;

    // configuration
    logic [PosW-1:0]  x_max_reg, y_max_reg;
    logic [GridW-1:0] cols_reg, rows_reg;

    // block state
    logic [PosW-1:0]  last_x_reg, last_x_next;
    logic [PosW-1:0]  last_y_reg, last_y_next;
    phase_t           phase_reg, phase_next;
    logic             numpad_reg, numpad_next;
    logic             held_valid_reg, held_valid_next;
    logic [KeyW-1:0]  held_row_reg, held_row_next;
    logic [KeyW-1:0]  held_col_reg, held_col_next;

    // sequencer and divider
    logic [1:0]       state_reg, state_next;
    logic             op_row_reg, op_row_next;
    logic [2:0]       cnt_reg, cnt_next;
    logic [DvdW-1:0]  rem_reg, rem_next;
    logic [DvsW-1:0]  dvs_reg, dvs_next;
    logic [4:0]       q_reg, q_next;
    logic             ovf_reg, ovf_next;
    logic [DvdW-1:0]  row_dvd_reg, row_dvd_next;
    logic [KeyW-1:0]  col_res_reg, col_res_next;

    // output register
    logic             out_valid_reg, out_valid_next;
    action_t          act_reg, act_next;
    logic [KeyW-1:0]  row_reg, row_next;
    logic [KeyW-1:0]  col_reg, col_next;

    logic             cfg_wr;
    logic             out_free;
    logic             accept;
    logic [PosW-1:0]  xm, ym;
    logic [GridW-1:0] cols_c, rows_c;
    logic [KeyW-1:0]  col_lim, row_lim;
    logic [23:0]      x100, y100, xm95, ym9, xm6, ym7;
    logic [DvdW-1:0]  num, ym3, col_dvd;
    logic [DvsW-1:0]  ym10;
    logic             top_right, top_left;
    logic [TrW-1:0]   trial_dvs;
    logic             ge;
    logic [4:0]       q_upd;
    logic             ovf_upd;
    logic [KeyW-1:0]  q_sat;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb
    begin
        prdata = '0;
        unique case (paddr)
            ADDR_X_MAX: prdata = PdataW'(x_max_reg);
            ADDR_Y_MAX: prdata = PdataW'(y_max_reg);
            ADDR_COLS:  prdata = PdataW'(cols_reg);
            ADDR_ROWS:  prdata = PdataW'(rows_reg);
            default:    prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_max_reg <= X_MAX_RST;
            y_max_reg <= Y_MAX_RST;
            cols_reg  <= COLS_RST;
            rows_reg  <= ROWS_RST;
        end
        else if (cfg_wr)
        begin
            unique case (paddr)
                ADDR_X_MAX: x_max_reg <= pwdata[PosW-1:0];
                ADDR_Y_MAX: y_max_reg <= pwdata[PosW-1:0];
                ADDR_COLS:  cols_reg  <= pwdata[GridW-1:0];
                ADDR_ROWS:  rows_reg  <= pwdata[GridW-1:0];
                default:    ;
            endcase
        end
    end

    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = (state_reg != S_IDLE) || !out_free;
    assign accept   = in_valid && !in_stall;

    assign out_valid  = out_valid_reg;
    assign action     = act_reg;
    assign key_row    = row_reg;
    assign key_column = col_reg;

    // zone arithmetic
    assign xm      = (x_max_reg == '0) ? 16'd1 : x_max_reg;
    assign ym      = (y_max_reg == '0) ? 16'd1 : y_max_reg;
    assign cols_c  = clamp_grid(cols_reg);
    assign rows_c  = clamp_grid(rows_reg);
    assign col_lim = KeyW'(cols_c - 5'd1);
    assign row_lim = KeyW'(rows_c - 5'd1);

    assign x100 = 24'(last_x_reg) * 24'd100;
    assign y100 = 24'(last_y_reg) * 24'd100;
    assign xm95 = 24'(xm) * 24'd95;
    assign ym9  = 24'(ym) * 24'd9;
    assign xm6  = 24'(xm) * 24'd6;
    assign ym7  = 24'(ym) * 24'd7;
    assign num  = DvdW'(rows_c) * DvdW'(last_y_reg) * DvdW'(10);
    assign ym3  = DvdW'(ym) * DvdW'(3);
    assign ym10 = DvsW'(ym) * DvsW'(10);
    assign col_dvd = DvdW'(cols_c) * DvdW'(last_x_reg);

    assign top_right = (x100 > xm95) && (y100 < ym9);
    assign top_left  = (x100 < xm6) && (y100 < ym7);

    // shared compare/subtract step
    assign trial_dvs = TrW'(dvs_reg) << cnt_reg;
    assign ge        = TrW'(rem_reg) >= trial_dvs;
    assign ovf_upd   = ovf_reg || ((cnt_reg == 3'd5) && ge);

    always_comb
    begin
        q_upd = q_reg;
        if (cnt_reg != 3'd5 && ge)
            q_upd[cnt_reg] = 1'b1;
    end

    always_comb
    begin
        logic [KeyW-1:0] lim;
        lim = op_row_reg ? row_lim : col_lim;
        if (ovf_upd || (q_upd > 5'(lim)))
            q_sat = lim;
        else
            q_sat = q_upd[KeyW-1:0];
    end

    always_comb
    begin
        last_x_next     = last_x_reg;
        last_y_next     = last_y_reg;
        phase_next      = phase_reg;
        numpad_next     = numpad_reg;
        held_valid_next = held_valid_reg;
        held_row_next   = held_row_reg;
        held_col_next   = held_col_reg;
        state_next      = state_reg;
        op_row_next     = op_row_reg;
        cnt_next        = cnt_reg;
        rem_next        = rem_reg;
        dvs_next        = dvs_reg;
        q_next          = q_reg;
        ovf_next        = ovf_reg;
        row_dvd_next    = row_dvd_reg;
        col_res_next    = col_res_reg;
        out_valid_next  = out_valid_reg && out_stall;
        act_next        = act_reg;
        row_next        = row_reg;
        col_next        = col_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    logic    start_div;
                    action_t a;
                    logic [KeyW-1:0] r, c;
                    start_div = 1'b0;
                    a = ACT_NONE;
                    r = '0;
                    c = '0;
                    case (event_kind)
                        KIND_X: last_x_next = event_value;
                        KIND_Y: last_y_next = event_value;
                        KIND_FINGER:
                        begin
                            if (event_value == 16'd0)
                            begin
                                phase_next = PH_IDLE;
                                if (held_valid_reg)
                                begin
                                    a = ACT_RELEASE;
                                    r = held_row_reg;
                                    c = held_col_reg;
                                    held_valid_next = 1'b0;
                                end
                            end
                            if (event_value == 16'd1 && phase_reg == PH_IDLE)
                                phase_next = PH_TOUCHED;
                            if (event_value == 16'd1 && top_right)
                            begin
                                phase_next  = PH_IDLE;
                                numpad_next = !numpad_reg;
                                a = numpad_reg ? ACT_OFF : ACT_ON;
                            end
                            else if (event_value == 16'd1 && top_left)
                            begin
                                phase_next = PH_IDLE;
                                a = ACT_BRIGHT;
                            end
                            if (numpad_next && phase_next == PH_TOUCHED)
                            begin
                                phase_next = PH_CONSUMED;
                                if (num >= ym3)
                                    start_div = 1'b1;
                            end
                        end
                        default: ;
                    endcase

                    if (start_div)
                    begin
                        state_next   = S_DIV;
                        op_row_next  = 1'b0;
                        cnt_next     = 3'd5;
                        rem_next     = col_dvd;
                        dvs_next     = DvsW'(xm);
                        q_next       = '0;
                        ovf_next     = 1'b0;
                        row_dvd_next = num - ym3;
                    end
                    else
                    begin
                        out_valid_next = 1'b1;
                        act_next = a;
                        row_next = r;
                        col_next = c;
                    end
                end
            end

            S_DIV:
            begin
                q_next   = q_upd;
                ovf_next = ovf_upd;
                if (cnt_reg != 3'd5 && ge)
                    rem_next = rem_reg - trial_dvs[DvdW-1:0];
                if (cnt_reg == 3'd0)
                begin
                    if (!op_row_reg)
                    begin
                        col_res_next = q_sat;
                        op_row_next  = 1'b1;
                        cnt_next     = 3'd5;
                        rem_next     = row_dvd_reg;
                        dvs_next     = ym10;
                        q_next       = '0;
                        ovf_next     = 1'b0;
                    end
                    else
                    begin
                        row_next   = q_sat;
                        state_next = S_OUT;
                    end
                end
                else
                begin
                    cnt_next = cnt_reg - 3'd1;
                end
            end

            S_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    act_next        = ACT_PRESS;
                    col_next        = col_res_reg;
                    held_valid_next = 1'b1;
                    held_row_next   = row_reg;
                    held_col_next   = col_res_reg;
                    state_next      = S_IDLE;
                end
            end

            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_x_reg     <= '0;
            last_y_reg     <= '0;
            phase_reg      <= PH_IDLE;
            numpad_reg     <= 1'b0;
            held_valid_reg <= 1'b0;
            held_row_reg   <= '0;
            held_col_reg   <= '0;
            state_reg      <= S_IDLE;
            op_row_reg     <= 1'b0;
            cnt_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            last_x_reg     <= last_x_next;
            last_y_reg     <= last_y_next;
            phase_reg      <= phase_next;
            numpad_reg     <= numpad_next;
            held_valid_reg <= held_valid_next;
            held_row_reg   <= held_row_next;
            held_col_reg   <= held_col_next;
            state_reg      <= state_next;
            op_row_reg     <= op_row_next;
            cnt_reg        <= cnt_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg     <= rem_next;
        dvs_reg     <= dvs_next;
        q_reg       <= q_next;
        ovf_reg     <= ovf_next;
        row_dvd_reg <= row_dvd_next;
        col_res_reg <= col_res_next;
        act_reg     <= act_next;
        row_reg     <= row_next;
        col_reg     <= col_next;
    end

endmodule
